@@ rtl/swaf_pkg.sv @@
// shared types and constants for the sliding window anagram finder
`timescale 1ns / 1ps
`default_nettype none

package swaf_pkg;

  localparam int ALPHABET  = 26;
  localparam int LETTER_W  = 5;
  localparam int OP_W      = 2;
  localparam int START_W   = 20;
  localparam int DIFF_W    = $clog2(ALPHABET + 1);
  localparam int IN_DATA_W = 8;
  localparam int OUT_DATA_W = 24;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR   = 2'd0,
    OP_PATTERN = 2'd1,
    OP_TEXT    = 2'd2
  } op_t;

  // per-bin update controls
  typedef struct packed {
    logic clr;
    logic pat_inc;
    logic win_inc;
    logic win_dec;
  } bin_ctrl_t;

  // change of the bin's mismatch state across this update
  typedef struct packed {
    logic rise;
    logic fall;
  } bin_stat_t;

endpackage

`default_nettype wire

@@ rtl/swaf_ram.sv @@
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module swaf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/swaf_bin.sv @@
// one histogram bin: pattern and window counts and their mismatch change
`timescale 1ns / 1ps
`default_nettype none

module swaf_bin import swaf_pkg::*; #(
  parameter int CNT_W = 7
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire bin_ctrl_t ctrl,
  output bin_stat_t      stat
);

  logic [CNT_W-1:0] pat_cnt;
  logic [CNT_W-1:0] win_cnt;
  logic [CNT_W-1:0] pat_cnt_next;
  logic [CNT_W-1:0] win_cnt_next;
  logic [CNT_W:0]   win_up;
  logic [CNT_W:0]   win_fin;
  logic             differs_now;
  logic             differs_next;

  always_comb begin
    pat_cnt_next = pat_cnt + CNT_W'(ctrl.pat_inc);
    win_up       = {1'b0, win_cnt} + (CNT_W+1)'(ctrl.win_inc);
    // the incoming letter is counted before the outgoing one leaves
    win_fin      = (ctrl.win_dec && (win_up != '0)) ? win_up - (CNT_W+1)'(1) : win_up;
    win_cnt_next = win_fin[CNT_W-1:0];
    differs_now  = pat_cnt != win_cnt;
    differs_next = {1'b0, pat_cnt_next} != win_fin;
    stat.rise    = !differs_now && differs_next;
    stat.fall    = differs_now && !differs_next;
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.clr) begin
      pat_cnt <= '0;
      win_cnt <= '0;
    end else begin
      pat_cnt <= pat_cnt_next;
      win_cnt <= win_cnt_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/sliding_window_anagram_finder_core.sv @@
// top level of the sliding window anagram finder
// a text letter gives its result through the input register and the result register;
// clear and pattern items give none; one item per cycle unless text waits on the output
// the delay line ram is read ahead, with a bypass for a one-letter pattern
// reset (rst, synchronous) empties both histograms and the pipeline registers
// and starts with no pattern, the same state that a clear item leaves
`timescale 1ns / 1ps
`default_nettype none

module sliding_window_anagram_finder_core import swaf_pkg::*; #(
  parameter int MAX_PATTERN   = 64,
  parameter int POSITION_BITS = 20
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,  // letter[4:0], zero fill
  input  wire logic [OP_W-1:0]       s_axis_tuser,  // operation[1:0]
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0]      m_axis_tdata   // window_full, match, start_index[19:0]
);

  localparam int LW = $clog2(MAX_PATTERN + 1);
  localparam int AW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int PB = POSITION_BITS;

  // input register
  logic                in_valid;
  logic [OP_W-1:0]     in_op;
  logic [LETTER_W-1:0] in_letter;

  // result register
  logic               out_valid;
  logic               out_full;
  logic               out_match;
  logic [START_W-1:0] out_start;

  // job state
  logic [LW-1:0]     pattern_len, pattern_len_next;
  logic [LW-1:0]     fill_count, fill_count_next;
  logic [PB-1:0]     text_count, text_count_next;
  logic [DIFF_W-1:0] diff_count, diff_count_next;
  logic              text_begun, text_begun_next;
  logic [AW-1:0]     wptr, wptr_next;

  logic                byp_hit;
  logic [LETTER_W-1:0] byp_letter;
  logic [LETTER_W-1:0] ram_rdata;
  logic [AW-1:0]       raddr;
  logic [LW-1:0]       rd_dist;
  logic [LW-1:0]       wptr_ext;

  logic                letter_ok, is_clear, is_pat, is_text;
  logic                out_free, advance;
  logic                do_pat, do_text, win_touch, drop, use_out;
  logic                has_len, was_full, full_now;
  logic [LETTER_W-1:0] outgoing;
  logic [1:0]          up_cnt, down_cnt;
  logic [PB-1:0]       start_pos;

  bin_ctrl_t bin_ctrl [ALPHABET];
  logic [ALPHABET-1:0] rise_vec;
  logic [ALPHABET-1:0] fall_vec;

  always_comb begin
    letter_ok = in_letter < LETTER_W'(ALPHABET);
    is_clear  = in_valid && (in_op == OP_CLEAR);
    is_pat    = in_valid && (in_op == OP_PATTERN) && letter_ok && !text_begun
                && (pattern_len < LW'(MAX_PATTERN));
    is_text   = in_valid && (in_op == OP_TEXT) && letter_ok;
    out_free  = !out_valid || m_axis_tready;
    advance   = in_valid && (!is_text || out_free);
    do_pat    = is_pat && advance;
    do_text   = is_text && advance;
    has_len   = pattern_len != '0;
    was_full  = fill_count >= pattern_len;
    win_touch = do_text && has_len;
    drop      = win_touch && was_full;
    outgoing  = byp_hit ? byp_letter : ram_rdata;
    // the outgoing bin only counts separately when it differs from the incoming one
    use_out   = drop && (outgoing != in_letter) && (outgoing < LETTER_W'(ALPHABET));
  end

  assign s_axis_tready = !in_valid || advance;

  genvar gi;
  generate
    for (gi = 0; gi < ALPHABET; gi++) begin : g_bin
      always_comb begin
        bin_ctrl[gi].clr     = is_clear;
        bin_ctrl[gi].pat_inc = do_pat && (in_letter == LETTER_W'(gi));
        bin_ctrl[gi].win_inc = win_touch && (in_letter == LETTER_W'(gi));
        bin_ctrl[gi].win_dec = drop && (outgoing == LETTER_W'(gi));
      end

      bin_stat_t stat;

      swaf_bin #(
        .CNT_W (LW)
      ) u_bin (
        .clk  (clk),
        .rst  (rst),
        .ctrl (bin_ctrl[gi]),
        .stat (stat)
      );

      assign rise_vec[gi] = stat.rise;
      assign fall_vec[gi] = stat.fall;
    end
  endgenerate

  always_comb begin
    up_cnt   = 2'(letter_ok && rise_vec[in_letter]) + 2'(use_out && rise_vec[outgoing]);
    down_cnt = 2'(letter_ok && fall_vec[in_letter]) + 2'(use_out && fall_vec[outgoing]);

    pattern_len_next = pattern_len;
    fill_count_next  = fill_count;
    text_count_next  = text_count;
    diff_count_next  = diff_count;
    text_begun_next  = text_begun;
    wptr_next        = wptr;

    if (is_clear) begin
      pattern_len_next = '0;
      fill_count_next  = '0;
      text_count_next  = '0;
      diff_count_next  = '0;
      text_begun_next  = 1'b0;
      wptr_next        = '0;
    end else begin
      if (do_pat || do_text) begin
        diff_count_next = diff_count + DIFF_W'(up_cnt) - DIFF_W'(down_cnt);
      end
      if (do_pat) begin
        pattern_len_next = pattern_len + LW'(1);
      end
      if (do_text) begin
        text_begun_next = 1'b1;
        text_count_next = text_count + PB'(1);
      end
      if (win_touch) begin
        if (!was_full) begin
          fill_count_next = fill_count + LW'(1);
        end
        wptr_next = (wptr == AW'(MAX_PATTERN - 1)) ? '0 : wptr + AW'(1);
      end
    end

    // prefetch the letter that leaves the window on the next text transaction
    wptr_ext = LW'(wptr_next);
    if (wptr_ext >= pattern_len_next) begin
      rd_dist = wptr_ext - pattern_len_next;
    end else begin
      rd_dist = (LW'(MAX_PATTERN) - pattern_len_next) + wptr_ext;
    end
    raddr = rd_dist[AW-1:0];

    full_now  = fill_count_next >= pattern_len;
    start_pos = text_count + PB'(1) - PB'(pattern_len);
  end

  swaf_ram #(
    .WIDTH (LETTER_W),
    .DEPTH (MAX_PATTERN)
  ) u_delay (
    .clk   (clk),
    .we    (win_touch),
    .waddr (wptr),
    .wdata (in_letter),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid    <= 1'b0;
      out_valid   <= 1'b0;
      pattern_len <= '0;
      fill_count  <= '0;
      text_count  <= '0;
      diff_count  <= '0;
      text_begun  <= 1'b0;
      wptr        <= '0;
      byp_hit     <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid <= s_axis_tvalid;
      end
      if (do_text) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
      pattern_len <= pattern_len_next;
      fill_count  <= fill_count_next;
      text_count  <= text_count_next;
      diff_count  <= diff_count_next;
      text_begun  <= text_begun_next;
      wptr        <= wptr_next;
      byp_hit     <= win_touch && (wptr == raddr);
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready) begin
      in_op     <= s_axis_tuser;
      in_letter <= s_axis_tdata[LETTER_W-1:0];
    end
    byp_letter <= in_letter;
    if (do_text) begin
      out_full  <= full_now;
      out_match <= full_now && has_len && (diff_count_next == '0);
      out_start <= START_W'(start_pos);
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(OUT_DATA_W - START_W - 2){1'b0}}, out_start, out_match, out_full};

  // the mismatch count never exceeds the number of bins
  a_diff_range: assert property (@(posedge clk) disable iff (rst)
    diff_count <= DIFF_W'(ALPHABET))
    else $error("mismatch count out of range");

  // the window never holds more letters than the pattern
  a_fill_le_len: assert property (@(posedge clk) disable iff (rst)
    fill_count <= pattern_len)
    else $error("window fill exceeds pattern length");

  // no letter enters the delay line before text has begun
  a_idle_line: assert property (@(posedge clk) disable iff (rst)
    !text_begun |-> (fill_count == '0) && (wptr == '0))
    else $error("delay line moved before text");

  // a match is only reported for a full window
  a_match_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_match |-> out_full)
    else $error("match without full window");

  // a text transaction always loads the result register next cycle
  a_result_load: assert property (@(posedge clk) disable iff (rst)
    do_text |=> out_valid)
    else $error("text transaction lost its result");

endmodule

`default_nettype wire

@@ sim/swaf_window_checker.sv @@
// stream monitor that predicts every window result of the anagram finder and compares it
`timescale 1ns / 1ps

module swaf_window_checker import swaf_pkg::*; #(
  parameter int MAX_PATTERN   = 64,
  parameter int POSITION_BITS = 20
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_axis_tvalid,
  input  wire logic                  s_axis_tready,
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,  // letter[4:0], zero fill
  input  wire logic [OP_W-1:0]       s_axis_tuser,  // operation[1:0]
  input  wire logic                  m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  input  wire logic [OUT_DATA_W-1:0] m_axis_tdata,  // window_full, match, start_index[19:0]
  output int                         mismatches,
  output int                         windows_pending
);

  localparam int BIN_W = $clog2(MAX_PATTERN + 1);

  typedef struct packed {
    logic               full;
    logic               match;
    logic [START_W-1:0] start;
  } window_t;

  logic [BIN_W-1:0]         pat_bins [ALPHABET];
  logic [BIN_W-1:0]         win_bins [ALPHABET];
  logic [LETTER_W-1:0]      recent [MAX_PATTERN];
  int                       pat_len;
  int                       fill;
  int                       wr_ptr;
  logic [POSITION_BITS-1:0] text_pos;
  logic [DIFF_W-1:0]        diff_bins;
  bit                       text_started;
  window_t                  expected_windows [$];

  initial begin
    mismatches = 0;
    windows_pending = 0;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t ns: mismatch on %s, got %0h, expected %0h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic clear_job();
    for (int b = 0; b < ALPHABET; b++) begin
      pat_bins[b] = '0;
      win_bins[b] = '0;
    end
    pat_len = 0;
    fill = 0;
    wr_ptr = 0;
    text_pos = '0;
    diff_bins = '0;
    text_started = 1'b0;
  endtask

  function automatic bit bin_differs(input int b);
    return pat_bins[b] != win_bins[b];
  endfunction

  // keep the count of differing bins in step with one bin update
  task automatic rebin(input int b, input bit differed);
    bit after;
    after = bin_differs(b);
    if (differed && !after)
      diff_bins = diff_bins - 1'b1;
    else if (!differed && after)
      diff_bins = diff_bins + 1'b1;
  endtask

  task automatic apply_item(input logic [OP_W-1:0] op, input logic [LETTER_W-1:0] ltr);
    int                       leaving;
    bit                       was_full;
    bit                       differed;
    logic [POSITION_BITS-1:0] first_pos;
    window_t                  w;
    if (op == OP_CLEAR) begin
      clear_job();
    end else if (ltr < ALPHABET) begin
      if (op == OP_PATTERN) begin
        if (!text_started && pat_len < MAX_PATTERN) begin
          differed = bin_differs(ltr);
          pat_bins[ltr] = pat_bins[ltr] + 1'b1;
          pat_len++;
          rebin(ltr, differed);
        end
      end else if (op == OP_TEXT) begin
        text_started = 1'b1;
        first_pos = text_pos + 1 - pat_len;
        text_pos = text_pos + 1'b1;
        if (pat_len > 0) begin
          leaving = recent[(wr_ptr + MAX_PATTERN - pat_len) % MAX_PATTERN];
          was_full = fill >= pat_len;
          recent[wr_ptr] = ltr;
          wr_ptr = (wr_ptr + 1) % MAX_PATTERN;
          differed = bin_differs(ltr);
          win_bins[ltr] = win_bins[ltr] + 1'b1;
          rebin(ltr, differed);
          if (was_full) begin
            differed = bin_differs(leaving);
            if (win_bins[leaving] != 0)
              win_bins[leaving] = win_bins[leaving] - 1'b1;
            rebin(leaving, differed);
          end else begin
            fill++;
          end
        end
        w.full = fill >= pat_len;
        // an empty pattern is never an anagram
        w.match = w.full && pat_len > 0 && diff_bins == 0;
        w.start = first_pos;
        expected_windows = {expected_windows, w};
      end
    end
  endtask

  always @(posedge clk) begin : watch
    window_t want;
    if (rst) begin
      clear_job();
      expected_windows.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_windows.size() == 0) begin
          report_mismatch("result with nothing expected", m_axis_tdata, '0);
        end else begin
          want = expected_windows.pop_front();
          if (m_axis_tdata[0] !== want.full)
            report_mismatch("window_full", m_axis_tdata[0], want.full);
          if (m_axis_tdata[1] !== want.match)
            report_mismatch("match", m_axis_tdata[1], want.match);
          if (m_axis_tdata[START_W+1:2] !== want.start)
            report_mismatch("start_index", m_axis_tdata[START_W+1:2], want.start);
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        apply_item(s_axis_tuser, s_axis_tdata[LETTER_W-1:0]);
    end
    windows_pending = expected_windows.size();
  end

endmodule

@@ sim/tb_sliding_window_anagram_finder_core.sv @@
// testbench top for the sliding window anagram finder: stimulus, stalls and verdict
`timescale 1ns / 1ps

module tb_sliding_window_anagram_finder_core;
  import swaf_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [OP_W-1:0]       s_axis_tuser = OP_CLEAR;
  logic                  m_axis_tready = 1'b0;
  wire                   s_axis_tready;
  wire                   m_axis_tvalid;
  wire [OUT_DATA_W-1:0]  m_axis_tdata;
  int                    mismatches;
  int                    windows_pending;
  int                    burst_left = 0;
  int                    ready_hold = 0;
  int                    items_sent = 0;
  bit                    steady = 1'b0;  // no idling on either side

  sliding_window_anagram_finder_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  swaf_window_checker checker_i (
    .clk             (clk),
    .rst             (rst),
    .s_axis_tvalid   (s_axis_tvalid),
    .s_axis_tready   (s_axis_tready),
    .s_axis_tdata    (s_axis_tdata),
    .s_axis_tuser    (s_axis_tuser),
    .m_axis_tvalid   (m_axis_tvalid),
    .m_axis_tready   (m_axis_tready),
    .m_axis_tdata    (m_axis_tdata),
    .mismatches      (mismatches),
    .windows_pending (windows_pending)
  );

  always #6 clk = ~clk;

  // receiver: alternating ready runs and stalls of random length
  always @(posedge clk) begin
    if (steady) begin
      m_axis_tready <= 1'b1;
    end else if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else begin
      m_axis_tready <= !m_axis_tready;
      if (m_axis_tready)
        ready_hold <= $urandom_range(0, 6);
      else
        ready_hold <= ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                                  : $urandom_range(0, 10);
    end
  end

  task automatic send_item(input logic [OP_W-1:0] op, input logic [LETTER_W-1:0] ltr);
    int gap;
    if (!steady && burst_left == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 5);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_DATA_W-LETTER_W){1'b0}}, ltr};
    s_axis_tuser  <= op;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (burst_left > 0) burst_left--;
    if (op != OP_UNUSED && ltr < ALPHABET) items_sent++;
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (windows_pending != 0) @(posedge clk);
  endtask

  function automatic logic [LETTER_W-1:0] pick_letter(input int base, input int span,
                                                      input bit noisy);
    if (noisy && $urandom_range(0, 5) == 0)
      return LETTER_W'($urandom_range(0, 31));
    return LETTER_W'(base + $urandom_range(0, span - 1));
  endfunction

  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin : stimulus
    int          pat_n;
    int          text_n;
    int          span;
    int          base;
    bit          noisy;
    logic [OP_W-1:0] op;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // pattern straight after reset, with the extreme letters
    send_item(OP_PATTERN, 5'd0);
    send_item(OP_PATTERN, 5'd25);
    send_item(OP_PATTERN, 5'd31);   // out of range
    send_item(OP_UNUSED, 5'd0);
    send_item(OP_TEXT, 5'd25);      // start index wraps below zero
    send_item(OP_TEXT, 5'd0);
    send_item(OP_TEXT, 5'd26);      // out of range
    send_item(OP_TEXT, 5'd0);
    send_item(OP_PATTERN, 5'd1);    // pattern letter after text has begun
    send_item(OP_TEXT, 5'd25);
    // empty pattern
    send_item(OP_CLEAR, 5'd31);
    send_item(OP_TEXT, 5'd0);
    send_item(OP_TEXT, 5'd25);
    send_item(OP_PATTERN, 5'd2);
    // one-letter pattern
    send_item(OP_CLEAR, 5'd0);
    send_item(OP_PATTERN, 5'd2);
    send_item(OP_TEXT, 5'd2);
    send_item(OP_TEXT, 5'd3);
    send_item(OP_TEXT, 5'd2);
    send_item(OP_UNUSED, 5'd31);
    // repeated letter
    send_item(OP_CLEAR, 5'd0);
    send_item(OP_PATTERN, 5'd1);
    send_item(OP_PATTERN, 5'd1);
    send_item(OP_TEXT, 5'd1);
    send_item(OP_TEXT, 5'd1);
    send_item(OP_TEXT, 5'd1);
    wait_drained();

    // random jobs: mostly clean clear / pattern / text sequences on a narrow alphabet
    while (items_sent < 640) begin
      noisy = $urandom_range(0, 4) == 0;
      span = ($urandom_range(0, 5) == 0) ? ALPHABET : $urandom_range(1, 3);
      base = $urandom_range(0, ALPHABET - span);
      case ($urandom_range(0, 9))
        0: pat_n = 0;
        1: pat_n = $urandom_range(60, 70);   // can run past the pattern limit
        default: pat_n = $urandom_range(1, 6);
      endcase
      text_n = (pat_n > 20) ? $urandom_range(pat_n, 2 * pat_n + 10) : $urandom_range(0, 30);
      if (pat_n > 20) span = $urandom_range(1, 2);
      if ($urandom_range(0, 9) != 0)
        send_item(OP_CLEAR, LETTER_W'($urandom_range(0, 31)));
      for (int k = 0; k < pat_n; k++)
        send_item(OP_PATTERN, pick_letter(base, span, noisy));
      for (int k = 0; k < text_n; k++) begin
        op = (noisy && $urandom_range(0, 7) == 0) ? OP_W'($urandom_range(0, 3)) : OP_TEXT;
        send_item(op, pick_letter(base, span, noisy));
      end
      if ($urandom_range(0, 7) == 0) wait_drained();
    end

    // a short job at full rate, back to back on both sides
    wait_drained();
    steady = 1'b1;
    send_item(OP_CLEAR, 5'd0);
    send_item(OP_PATTERN, 5'd0);
    send_item(OP_PATTERN, 5'd1);
    for (int k = 0; k < 40; k++)
      send_item(OP_TEXT, LETTER_W'($urandom_range(0, 1)));
    steady = 1'b0;

    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatches == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

@@ files.f @@
rtl/swaf_pkg.sv
rtl/swaf_ram.sv
rtl/swaf_bin.sv
rtl/sliding_window_anagram_finder_core.sv
sim/swaf_window_checker.sv
sim/tb_sliding_window_anagram_finder_core.sv
